[rtl/core/mgti_pkg.sv]
// Shared types and field widths for the GOP timecode indexer.
// No dependencies; every other file of the block refers to it by scoped name.
`default_nettype none

package mgti_pkg;

	localparam int BYTE_W  = 8;
	localparam int HOURS_W = 5;
	localparam int MIN_W   = 6;
	localparam int SEC_W   = 6;
	localparam int FRM_W   = 6;
	localparam int FRAME_W = 23;
	localparam int POS_W   = 48;

	// Strobes from the controller to the datapath
	typedef struct packed {
		logic take;      // input transaction this cycle
		logic start;     // header passed: latch timecode and position
		logic mul;       // seconds total times 2997
		logic div;       // divide product by 100
		logic load_out;  // move finished result into output register
	} mgti_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic hdr_pass;  // current byte completes a header that passes the checks
		logic out_free;  // output register can take a result this cycle
	} mgti_status_t;

endpackage

`default_nettype wire

[rtl/core/mgti_if.sv]
// Stream channel interfaces: byte input and index result output.
// Depends on mgti_pkg for field widths.
`default_nettype none

interface mgti_in_if;
	logic                          valid;
	logic                          ready;
	logic [mgti_pkg::BYTE_W-1:0]   data_byte;
	logic                          new_recording;

	modport source (output valid, output data_byte, output new_recording, input ready);
	modport sink   (input valid, input data_byte, input new_recording, output ready);
endinterface

interface mgti_out_if;
	logic                          valid;
	logic                          ready;
	logic [mgti_pkg::FRAME_W-1:0]  frame_count;
	logic [mgti_pkg::POS_W-1:0]    byte_position;
	logic [mgti_pkg::HOURS_W-1:0]  tc_hours;
	logic [mgti_pkg::MIN_W-1:0]    tc_minutes;
	logic [mgti_pkg::SEC_W-1:0]    tc_seconds;
	logic [mgti_pkg::FRM_W-1:0]    tc_frames;

	modport source (output valid, output frame_count, output byte_position, output tc_hours,
		output tc_minutes, output tc_seconds, output tc_frames, input ready);
	modport sink   (input valid, input frame_count, input byte_position, input tc_hours,
		input tc_minutes, input tc_seconds, input tc_frames, output ready);
endinterface

`default_nettype wire

[rtl/core/mgti_ctrl.sv]
// Sequencer for the GOP timecode indexer: byte intake and the frame arithmetic steps.
// Depends on mgti_pkg for the command and status structs.
`default_nettype none

module mgti_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  mgti_pkg::mgti_status_t status,
	output mgti_pkg::mgti_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_SUM,
		ST_WAIT
	} state_t;

	state_t state_q;
	logic   take;
	logic   finishing;

	// Hold off the stream only while a result is stuck behind a full output register
	assign in_ready  = (state_q != ST_WAIT);
	assign take      = in_valid & in_ready;
	assign finishing = (state_q == ST_SUM) || (state_q == ST_WAIT);

	always_comb begin
		cmd          = '0;
		cmd.take     = take;
		cmd.start    = take & status.hdr_pass;
		cmd.mul      = (state_q == ST_MUL);
		cmd.div      = (state_q == ST_DIV);
		cmd.load_out = finishing & status.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (take && status.hdr_pass) state_q <= ST_MUL;
				end
				ST_MUL: state_q <= ST_DIV;
				ST_DIV: state_q <= ST_SUM;
				ST_SUM, ST_WAIT: begin
					if (status.out_free) state_q <= ST_IDLE;
					else state_q <= ST_WAIT;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/core/mgti_dp.sv]
// Datapath of the GOP timecode indexer: byte history, start code match, plausibility
// checks, frame number arithmetic and the output register. Depends on mgti_pkg.
`default_nettype none

module mgti_dp #(
	parameter int POSITION_BITS = 48
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [mgti_pkg::BYTE_W-1:0]   data_byte,
	input  logic                          new_recording,
	input  logic                          out_ready,
	input  mgti_pkg::mgti_cmd_t           cmd,
	output mgti_pkg::mgti_status_t        status,
	output logic                          out_valid,
	output logic [mgti_pkg::FRAME_W-1:0]  frame_count,
	output logic [mgti_pkg::POS_W-1:0]    byte_position,
	output logic [mgti_pkg::HOURS_W-1:0]  tc_hours,
	output logic [mgti_pkg::MIN_W-1:0]    tc_minutes,
	output logic [mgti_pkg::SEC_W-1:0]    tc_seconds,
	output logic [mgti_pkg::FRM_W-1:0]    tc_frames
);

	localparam int HIST_W   = 7 * mgti_pkg::BYTE_W;
	localparam int SECS_W   = 17;   // hours*3600 + minutes*60 + seconds, at most 115443
	localparam int PROD_W   = 29;   // that total times 2997
	localparam int QUOT_W   = 22;   // product divided by 100
	localparam int RECIP_SH = 35;
	localparam int EXT_W    = (POSITION_BITS > mgti_pkg::POS_W) ? POSITION_BITS
		: mgti_pkg::POS_W;

	localparam logic [31:0] START_CODE = 32'h0000_01B8;
	localparam logic [mgti_pkg::FRAME_W-1:0] WRAP_FRAMES =
		mgti_pkg::FRAME_W'(31 * 60 * 60 * 2997 / 100);
	// ceil(2^35 / 100); exact quotient for every product below 2^30
	localparam logic [PROD_W-1:0] RECIP_100 = PROD_W'(343597384);

	// Plausibility of a timecode against the reference time
	function automatic logic implausible(
		input logic [mgti_pkg::HOURS_W-1:0] h,
		input logic [mgti_pkg::MIN_W-1:0]   m,
		input logic [mgti_pkg::SEC_W-1:0]   s,
		input logic [mgti_pkg::HOURS_W-1:0] ph,
		input logic [mgti_pkg::MIN_W-1:0]   pm,
		input logic [mgti_pkg::SEC_W-1:0]   ps
	);
		logic                          bad;
		logic [mgti_pkg::MIN_W:0]      m_inc;
		logic [mgti_pkg::MIN_W-1:0]    m_next;
		logic [mgti_pkg::HOURS_W-1:0]  h_next;
		m_inc  = {1'b0, pm} + 7'd1;
		m_next = (m_inc >= 7'd60) ? 6'(m_inc - 7'd60) : m_inc[5:0];
		h_next = ph + 5'd1;
		bad    = 1'b0;
		if (s != ps) begin
			if ({1'b0, s} > ({1'b0, ps} + 7'd3)) bad = 1'b1;
			if ((s < 6'd2) && (ps > 6'd2) && (ps < 6'd58)) bad = 1'b1;
			if ((s < ps) && (ps < 6'd58)) bad = 1'b1;
			if ((s == 6'd0) && (m != m_next)) bad = 1'b1;
		end
		if (m != pm) begin
			if (m != m_next) bad = 1'b1;
			if (s > 6'd5) bad = 1'b1;
			if (ps < 6'd55) bad = 1'b1;
			if ((m == 6'd0) && (h != h_next)) bad = 1'b1;
		end
		if (h != ph) begin
			if (h != h_next) bad = 1'b1;
			if (m > 6'd0) bad = 1'b1;
			if (pm < 6'd59) bad = 1'b1;
		end
		return bad;
	endfunction

	// Stream state
	logic [HIST_W-1:0]              recent_q;
	logic [POSITION_BITS-1:0]       count_q;
	logic                           base_valid_q;
	logic [mgti_pkg::FRAME_W-1:0]   base_q;
	logic                           base_pend_q;
	logic [2:0]                     bogus_q;
	logic [mgti_pkg::HOURS_W-1:0]   prev_h_q;
	logic [mgti_pkg::MIN_W-1:0]     prev_m_q;
	logic [mgti_pkg::SEC_W-1:0]     prev_s_q;

	// Header under arithmetic
	logic [mgti_pkg::HOURS_W-1:0]   hdr_h_q;
	logic [mgti_pkg::MIN_W-1:0]     hdr_m_q;
	logic [mgti_pkg::SEC_W-1:0]     hdr_s_q;
	logic [mgti_pkg::FRM_W-1:0]     hdr_f_q;
	logic [mgti_pkg::POS_W-1:0]     hdr_pos_q;
	logic                           hdr_first_q;
	logic [mgti_pkg::FRAME_W-1:0]   hdr_base_q;
	logic [PROD_W-1:0]              prod_q;
	logic [QUOT_W-1:0]              quot_q;

	// Output register
	logic                           out_valid_q;
	logic [mgti_pkg::FRAME_W-1:0]   frame_q;
	logic [mgti_pkg::POS_W-1:0]     pos_q;
	logic [mgti_pkg::HOURS_W-1:0]   h_q;
	logic [mgti_pkg::MIN_W-1:0]     m_q;
	logic [mgti_pkg::SEC_W-1:0]     s_q;
	logic [mgti_pkg::FRM_W-1:0]     f_q;

	// Header decode on the current byte
	logic                           header;
	logic                           first;
	logic [2:0]                     bogus_eff;
	logic                           refresh;
	logic                           bad;
	logic [mgti_pkg::HOURS_W-1:0]   cur_h;
	logic [mgti_pkg::MIN_W-1:0]     cur_m;
	logic [mgti_pkg::SEC_W-1:0]     cur_s;
	logic [mgti_pkg::FRM_W-1:0]     cur_f;
	logic [mgti_pkg::HOURS_W-1:0]   ref_h;
	logic [mgti_pkg::MIN_W-1:0]     ref_m;
	logic [mgti_pkg::SEC_W-1:0]     ref_s;
	logic [POSITION_BITS-1:0]       pos_full;
	logic [EXT_W-1:0]               pos_ext;

	// Arithmetic
	logic [SECS_W-1:0]              secs;
	logic [2*PROD_W-1:0]            recip_prod;
	logic [mgti_pkg::FRAME_W-1:0]   frame_x;
	logic [mgti_pkg::FRAME_W-1:0]   base_sel;
	logic [mgti_pkg::FRAME_W-1:0]   frame_w;

	assign header = !new_recording && (count_q >= POSITION_BITS'(7))
		&& (recent_q[HIST_W-1:24] == START_CODE);

	assign cur_h = recent_q[22:18];
	assign cur_m = {recent_q[17:16], recent_q[15:12]};
	assign cur_s = {recent_q[10:8], recent_q[7:5]};
	assign cur_f = {recent_q[4:0], data_byte[7]};

	// First header sets the reference; a long reject run takes this header's time
	assign first     = !base_valid_q;
	assign bogus_eff = first ? 3'd1 : bogus_q;
	assign refresh   = first || (bogus_eff > 3'd3);
	assign ref_h     = refresh ? cur_h : prev_h_q;
	assign ref_m     = refresh ? cur_m : prev_m_q;
	assign ref_s     = refresh ? cur_s : prev_s_q;
	assign bad       = implausible(cur_h, cur_m, cur_s, ref_h, ref_m, ref_s);

	assign pos_full = count_q - POSITION_BITS'(7);
	assign pos_ext  = EXT_W'(pos_full);

	assign status.hdr_pass = header & !bad;
	assign status.out_free = !out_valid_q || out_ready;

	assign secs = SECS_W'(hdr_h_q) * SECS_W'(3600) + SECS_W'(hdr_m_q) * SECS_W'(60)
		+ SECS_W'(hdr_s_q);
	assign recip_prod = prod_q * RECIP_100;

	assign frame_x  = mgti_pkg::FRAME_W'(quot_q) + mgti_pkg::FRAME_W'(hdr_f_q);
	assign base_sel = hdr_first_q ? frame_x : hdr_base_q;
	assign frame_w  = (frame_x < base_sel) ? (frame_x + WRAP_FRAMES) : frame_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q     <= '0;
			count_q      <= '0;
			base_valid_q <= 1'b0;
			base_q       <= '0;
			base_pend_q  <= 1'b0;
			bogus_q      <= '0;
			prev_h_q     <= '0;
			prev_m_q     <= '0;
			prev_s_q     <= '0;
		end else begin
			if (cmd.take && new_recording) begin
				recent_q     <= HIST_W'(data_byte);
				count_q      <= POSITION_BITS'(1);
				base_valid_q <= 1'b0;
				base_q       <= '0;
				base_pend_q  <= 1'b0;
				bogus_q      <= '0;
				prev_h_q     <= '0;
				prev_m_q     <= '0;
				prev_s_q     <= '0;
			end else begin
				// First header's frame number lands as the base once it is known
				if (cmd.load_out && base_pend_q) begin
					base_q      <= frame_x;
					base_pend_q <= 1'b0;
				end else if (cmd.start && first) begin
					base_pend_q <= 1'b1;
				end
				if (cmd.take) begin
					recent_q <= {recent_q[HIST_W-mgti_pkg::BYTE_W-1:0], data_byte};
					count_q  <= count_q + POSITION_BITS'(1);
					if (header) begin
						base_valid_q <= 1'b1;
						if (bad) begin
							bogus_q  <= (bogus_eff < 3'd7) ? (bogus_eff + 3'd1) : bogus_eff;
							prev_h_q <= ref_h;
							prev_m_q <= ref_m;
							prev_s_q <= ref_s;
						end else begin
							bogus_q  <= '0;
							prev_h_q <= cur_h;
							prev_m_q <= cur_m;
							prev_s_q <= cur_s;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			hdr_h_q     <= cur_h;
			hdr_m_q     <= cur_m;
			hdr_s_q     <= cur_s;
			hdr_f_q     <= cur_f;
			hdr_pos_q   <= pos_ext[mgti_pkg::POS_W-1:0];
			hdr_first_q <= first;
			hdr_base_q  <= base_q;
		end
		if (cmd.mul) prod_q <= PROD_W'(secs) * PROD_W'(2997);
		if (cmd.div) quot_q <= recip_prod[RECIP_SH +: QUOT_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			frame_q <= frame_w - base_sel;
			pos_q   <= hdr_pos_q;
			h_q     <= hdr_h_q;
			m_q     <= hdr_m_q;
			s_q     <= hdr_s_q;
			f_q     <= hdr_f_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign frame_count   = frame_q;
	assign byte_position = pos_q;
	assign tc_hours      = h_q;
	assign tc_minutes    = m_q;
	assign tc_seconds    = s_q;
	assign tc_frames     = f_q;

endmodule

`default_nettype wire

[rtl/core/mpeg_gop_timecode_indexer.sv]
// GOP timecode indexer. Takes one stream byte per cycle on the stream channel, matches
// the start code 00 00 01 B8 with its four timecode bytes at every offset, and for each
// header that passes the plausibility checks sends the 29.97 fps frame count relative to
// the first header since reset or new recording, the byte offset of the header and its
// timecode on the index channel. A passing header starts the arithmetic steps in the datapath
// (multiply by 2997, reciprocal divide by 100, wrap and base subtract), after which the
// result enters the output register. Bytes keep flowing during those steps; the stream
// stalls only while a finished result waits for a full output register to drain. There
// is no clearing pass after reset.
// Depends on mgti_pkg, mgti_if, mgti_ctrl and mgti_dp.
`default_nettype none

module mpeg_gop_timecode_indexer #(
	parameter int POSITION_BITS = 48
) (
	input  logic       clk,
	input  logic       arst_n,
	mgti_in_if.sink    stream,
	mgti_out_if.source index
);

	mgti_pkg::mgti_cmd_t    cmd;
	mgti_pkg::mgti_status_t status;
	logic                   in_ready;
	logic                   out_valid;

	mgti_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (stream.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	mgti_dp #(
		.POSITION_BITS (POSITION_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.data_byte     (stream.data_byte),
		.new_recording (stream.new_recording),
		.out_ready     (index.ready),
		.cmd           (cmd),
		.status        (status),
		.out_valid     (out_valid),
		.frame_count   (index.frame_count),
		.byte_position (index.byte_position),
		.tc_hours      (index.tc_hours),
		.tc_minutes    (index.tc_minutes),
		.tc_seconds    (index.tc_seconds),
		.tc_frames     (index.tc_frames)
	);

	assign stream.ready = in_ready;
	assign index.valid  = out_valid;

endmodule

`default_nettype wire
